// ===== rtl/ttrad_pkg.sv =====
`timescale 1ns / 1ps

package ttrad_pkg;

   // Field widths fixed by the cell format
   localparam int ROW_W    = 5;
   localparam int COL_W    = 6;
   localparam int GLYPH_W  = 16;
   localparam int COLOUR_W = 3;

   // Attribute reset values
   localparam logic [COLOUR_W-1:0] COLOUR_WHITE = 3'd7;
   localparam logic [COLOUR_W-1:0] COLOUR_BLACK = 3'd0;

   // Byte codes
   localparam logic [6:0] CODE_ESC       = 7'h1B;
   localparam logic [7:0] CODE_ESC_CTL   = 8'h1B;
   localparam logic [7:0] CODE_SPACE     = 8'h20;
   localparam logic [7:0] ESC_OFFSET     = 8'h40;
   localparam logic [7:0] CODE_TALL_OFF  = 8'h0C;
   localparam logic [7:0] CODE_TALL_ON   = 8'h0D;
   localparam logic [7:0] CODE_SEP_OFF   = 8'h19;
   localparam logic [7:0] CODE_SEP_ON    = 8'h1A;
   localparam logic [7:0] CODE_BACK_BLK  = 8'h1C;
   localparam logic [7:0] CODE_BACK_NEW  = 8'h1D;
   localparam logic [7:0] CODE_DIVIDE    = 8'h7E;
   localparam logic [7:0] CODE_BLOCK     = 8'h7F;

   // Glyph codes
   localparam logic [GLYPH_W-1:0] GLYPH_SPACE      = 16'h0020;
   localparam logic [GLYPH_W-1:0] GLYPH_DIVIDE     = 16'h00F7;
   localparam logic [GLYPH_W-1:0] GLYPH_BLOCK      = 16'hE65F;
   localparam logic [GLYPH_W-1:0] GLYPH_MOS_LO     = 16'hE680;
   localparam logic [GLYPH_W-1:0] GLYPH_MOS_LO_SEP = 16'hE6A0;
   localparam logic [GLYPH_W-1:0] GLYPH_MOS_HI     = 16'hE6C0;
   localparam logic [GLYPH_W-1:0] GLYPH_MOS_HI_SEP = 16'hE6E0;

   typedef struct packed {
      logic [7:0]       byte_in;
      logic             row_start;
      logic             row_end;
      logic [ROW_W-1:0] row_number;
   } req_item_type;

   typedef struct packed {
      logic [ROW_W-1:0]    cell_row;
      logic [COL_W-1:0]    cell_column;
      logic [GLYPH_W-1:0]  glyph_code;
      logic [COLOUR_W-1:0] fore_colour;
      logic [COLOUR_W-1:0] back_colour;
      logic                mosaic_on;
      logic                mosaic_separated;
      logic                tall_cell;
      logic                spacing_control;
      logic                last_of_run;
   } cell_type;

   typedef struct packed {
      logic [COLOUR_W-1:0] fore;
      logic [COLOUR_W-1:0] back;
      logic                mosaic;
      logic                separated;
      logic                tall;
      logic [COL_W-1:0]    column;
      logic                esc_pending;
   } attr_state_type;

endpackage

// ===== rtl/ttrad_if.sv =====
`timescale 1ns / 1ps

// Input byte channel
interface ttrad_req_if import ttrad_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [7:0]       byte_in;
   logic             row_start;
   logic             row_end;
   logic [ROW_W-1:0] row_number;

   modport source (output valid, byte_in, row_start, row_end, row_number, input ready);
   modport sink   (input valid, byte_in, row_start, row_end, row_number, output ready);
endinterface

// Decoded cell channel
interface ttrad_rsp_if import ttrad_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ROW_W-1:0]    cell_row;
   logic [COL_W-1:0]    cell_column;
   logic [GLYPH_W-1:0]  glyph_code;
   logic [COLOUR_W-1:0] fore_colour;
   logic [COLOUR_W-1:0] back_colour;
   logic                mosaic_on;
   logic                mosaic_separated;
   logic                tall_cell;
   logic                spacing_control;
   logic                last_of_run;

   modport source (output valid, cell_row, cell_column, glyph_code, fore_colour,
                   back_colour, mosaic_on, mosaic_separated, tall_cell,
                   spacing_control, last_of_run, input ready);
   modport sink   (input valid, cell_row, cell_column, glyph_code, fore_colour,
                   back_colour, mosaic_on, mosaic_separated, tall_cell,
                   spacing_control, last_of_run, output ready);
endinterface

// ===== rtl/teletext_row_attribute_decoder.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// req_bus   in   valid/ready          byte_in, row_start, row_end, row_number
// rsp_bus   out  valid/ready          one decoded cell, last_of_run ends a byte's cells
// csr_*     in   write enable only    escape_mode
//
// One byte per cycle while rsp_bus.ready is high and no filler cell is going out;
// bytes pass the input register, then the output register. On a row 0 start the
// decoder holds the byte while HEADER_SKIP filler cells go out, one per cycle if ready.
// Reset is synchronous and clears attributes, column, pending escape, and
// sets escape mode. rsp_bus.ready low holds the output cell; the input register
// then fills and req_bus.ready drops.

module teletext_row_attribute_decoder import ttrad_pkg::*; #(
   parameter int COLUMNS     = 40,
   parameter int ROWS        = 25,
   parameter int HEADER_SKIP = 8
) (
   input  logic        clock,
   input  logic        reset,
   ttrad_req_if.sink   req_bus,
   ttrad_rsp_if.source rsp_bus,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   logic         consume;
   logic         item_valid;
   req_item_type item;
   logic         out_free;
   logic         cell_load;
   cell_type     dec_cell;

   ttrad_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .consume    (consume),
      .item_valid (item_valid),
      .item       (item)
   );

   ttrad_decode #(
      .COLUMNS     (COLUMNS),
      .ROWS        (ROWS),
      .HEADER_SKIP (HEADER_SKIP)
   ) u_decode (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item             (item),
      .out_free         (out_free),
      .consume          (consume),
      .cell_load        (cell_load),
      .dec_cell         (dec_cell)
   );

   ttrad_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .cell_load (cell_load),
      .dec_cell  (dec_cell),
      .out_free  (out_free),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== rtl/ttrad_in_reg.sv =====
`timescale 1ns / 1ps

module ttrad_in_reg import ttrad_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ttrad_req_if.sink    req_bus,
   input  logic         consume,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   // Take a new byte when empty or when the held one leaves this cycle
   assign req_bus.ready = !valid_ff || consume;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.byte_in    <= req_bus.byte_in;
         item_ff.row_start  <= req_bus.row_start;
         item_ff.row_end    <= req_bus.row_end;
         item_ff.row_number <= req_bus.row_number;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/ttrad_decode.sv =====
`timescale 1ns / 1ps

module ttrad_decode import ttrad_pkg::*; #(
   parameter int COLUMNS     = 40,
   parameter int ROWS        = 25,
   parameter int HEADER_SKIP = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic         csr_write_data,
   input  logic         item_valid,
   input  req_item_type item,
   input  logic         out_free,
   output logic         consume,
   output logic         cell_load,
   output cell_type     dec_cell
);

   localparam int FILL_W = $clog2(HEADER_SKIP + 2);

   logic           escape_mode_ff;
   attr_state_type state_ff;
   attr_state_type state_in;
   logic [FILL_W-1:0] fill_cnt_ff;
   logic [FILL_W-1:0] fill_cnt_in;

   attr_state_type eff;
   attr_state_type upd;
   logic           in_range;
   logic           header_start;
   logic           filling;
   logic           last_fill;
   logic           col_ok;
   logic           has_char;
   logic           main_emits;
   logic [7:0]     ch;
   logic           commit;
   cell_type       main_cell;
   cell_type       fill_cell;

   // Escape mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_mode_ff <= 1'b1;
      end else if (csr_write_enable) begin
         escape_mode_ff <= csr_write_data;
      end
   end

   assign in_range     = {1'b0, item.row_number} < (ROW_W + 1)'(ROWS);
   assign header_start = item.row_start && (item.row_number == '0);
   assign filling      = item_valid && in_range && header_start
                         && (fill_cnt_ff < FILL_W'(HEADER_SKIP));
   assign last_fill    = fill_cnt_ff == FILL_W'(HEADER_SKIP - 1);

   // State seen by this byte: row start resets it first, column to HEADER_SKIP on row 0, else 0
   always_comb begin
      eff = state_ff;
      if (item.row_start) begin
         eff.fore        = COLOUR_WHITE;
         eff.back        = COLOUR_BLACK;
         eff.mosaic      = 1'b0;
         eff.separated   = 1'b0;
         eff.tall        = 1'b0;
         eff.esc_pending = 1'b0;
         eff.column      = header_start ? COL_W'(HEADER_SKIP) : '0;
      end
   end

   assign col_ok = eff.column < COL_W'(COLUMNS);

   // Character after escape handling
   always_comb begin
      upd      = eff;
      has_char = 1'b1;
      ch       = {1'b0, item.byte_in[6:0]};
      if (eff.esc_pending) begin
         ch              = {1'b0, item.byte_in[6:0]} - ESC_OFFSET;
         upd.esc_pending = 1'b0;
      end else if (item.byte_in[6:0] == CODE_ESC) begin
         if (escape_mode_ff && !item.row_end) begin
            has_char        = 1'b0;
            upd.esc_pending = 1'b1;
         end else begin
            ch = escape_mode_ff ? CODE_ESC_CTL : CODE_SPACE;
         end
      end

      // Serial attribute updates
      if (has_char && ch < CODE_SPACE) begin
         unique case (ch) inside
            [8'h00:8'h07]: begin
               upd.fore   = ch[2:0];
               upd.mosaic = 1'b0;
            end
            [8'h10:8'h17]: begin
               upd.fore   = ch[2:0];
               upd.mosaic = 1'b1;
            end
            CODE_SEP_OFF:  upd.separated = 1'b0;
            CODE_SEP_ON:   upd.separated = 1'b1;
            CODE_BACK_BLK: upd.back      = COLOUR_BLACK;
            CODE_BACK_NEW: upd.back      = eff.fore;
            CODE_TALL_ON:  upd.tall      = 1'b1;
            CODE_TALL_OFF: upd.tall      = 1'b0;
            default: ;
         endcase
      end
      if (has_char) begin
         upd.column = eff.column + COL_W'(1);
      end
   end

   assign main_emits = col_ok && has_char;

   // Decoded cell
   always_comb begin
      main_cell.cell_row         = item.row_number;
      main_cell.cell_column      = eff.column;
      main_cell.fore_colour      = upd.fore;
      main_cell.back_colour      = upd.back;
      main_cell.tall_cell        = upd.tall;
      main_cell.last_of_run      = 1'b1;
      if (ch < CODE_SPACE) begin
         main_cell.glyph_code       = GLYPH_SPACE;
         main_cell.mosaic_on        = 1'b0;
         main_cell.mosaic_separated = 1'b0;
         main_cell.spacing_control  = 1'b1;
      end else begin
         main_cell.mosaic_on        = eff.mosaic;
         main_cell.mosaic_separated = eff.separated;
         main_cell.spacing_control  = 1'b0;
         if (eff.mosaic && !ch[7]) begin
            if (ch[6:5] == 2'b10) begin
               main_cell.glyph_code = {8'h00, ch};
            end else if (!ch[6]) begin
               main_cell.glyph_code = (eff.separated ? GLYPH_MOS_LO_SEP : GLYPH_MOS_LO)
                                      | {11'b0, ch[4:0]};
            end else begin
               main_cell.glyph_code = (eff.separated ? GLYPH_MOS_HI_SEP : GLYPH_MOS_HI)
                                      | {11'b0, ch[4:0]};
            end
         end else if (ch == CODE_DIVIDE) begin
            main_cell.glyph_code = GLYPH_DIVIDE;
         end else if (ch == CODE_BLOCK) begin
            main_cell.glyph_code = GLYPH_BLOCK;
         end else begin
            main_cell.glyph_code = {8'h00, ch};
         end
      end
   end

   // Header filler cell
   always_comb begin
      fill_cell.cell_row         = item.row_number;
      fill_cell.cell_column      = COL_W'(fill_cnt_ff);
      fill_cell.glyph_code       = GLYPH_SPACE;
      fill_cell.fore_colour      = COLOUR_WHITE;
      fill_cell.back_colour      = COLOUR_BLACK;
      fill_cell.mosaic_on        = 1'b0;
      fill_cell.mosaic_separated = 1'b0;
      fill_cell.tall_cell        = 1'b0;
      fill_cell.spacing_control  = 1'b0;
      fill_cell.last_of_run      = last_fill && !main_emits;
   end

   // Transfer control
   always_comb begin
      consume   = 1'b0;
      cell_load = 1'b0;
      commit    = 1'b0;
      dec_cell  = main_cell;
      if (item_valid) begin
         if (!in_range) begin
            consume = 1'b1;
         end else if (filling) begin
            dec_cell = fill_cell;
            if (out_free) begin
               cell_load = 1'b1;
               if (last_fill && !main_emits) begin
                  consume = 1'b1;
                  commit  = 1'b1;
               end
            end
         end else if (main_emits) begin
            if (out_free) begin
               cell_load = 1'b1;
               consume   = 1'b1;
               commit    = 1'b1;
            end
         end else begin
            consume = 1'b1;
            commit  = 1'b1;
         end
      end
   end

   // Next attribute state and filler count
   always_comb begin
      state_in    = state_ff;
      fill_cnt_in = fill_cnt_ff;
      if (commit) begin
         state_in = col_ok ? upd : eff;
      end
      if (consume) begin
         fill_cnt_in = '0;
      end else if (cell_load) begin
         fill_cnt_in = fill_cnt_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.fore        <= COLOUR_WHITE;
         state_ff.back        <= COLOUR_BLACK;
         state_ff.mosaic      <= 1'b0;
         state_ff.separated   <= 1'b0;
         state_ff.tall        <= 1'b0;
         state_ff.column      <= '0;
         state_ff.esc_pending <= 1'b0;
         fill_cnt_ff          <= '0;
      end else begin
         state_ff    <= state_in;
         fill_cnt_ff <= fill_cnt_in;
      end
   end

   // Checks
   a_load_needs_space: assert property (@(posedge clock) disable iff (reset)
      cell_load |-> out_free) else $error("cell loaded into a full output register");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_cnt_ff <= FILL_W'(HEADER_SKIP)) else $error("filler count overrun");

   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.column <= COL_W'(COLUMNS)) else $error("column beyond row end");

   a_idle_fill_clear: assert property (@(posedge clock) disable iff (reset)
      !item_valid |-> fill_cnt_ff == '0) else $error("filler count left over");

   a_consume_valid: assert property (@(posedge clock) disable iff (reset)
      consume |-> item_valid) else $error("consume without a held byte");

endmodule

// ===== rtl/ttrad_out_reg.sv =====
`timescale 1ns / 1ps

module ttrad_out_reg import ttrad_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       cell_load,
   input  cell_type   dec_cell,
   output logic       out_free,
   ttrad_rsp_if.source rsp_bus
);

   logic     valid_ff;
   logic     valid_in;
   cell_type cell_ff;

   // Free when empty or the held cell transfers this cycle
   assign out_free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (cell_load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_load) begin
         cell_ff <= dec_cell;
      end
   end

   assign rsp_bus.valid            = valid_ff;
   assign rsp_bus.cell_row         = cell_ff.cell_row;
   assign rsp_bus.cell_column      = cell_ff.cell_column;
   assign rsp_bus.glyph_code       = cell_ff.glyph_code;
   assign rsp_bus.fore_colour      = cell_ff.fore_colour;
   assign rsp_bus.back_colour      = cell_ff.back_colour;
   assign rsp_bus.mosaic_on        = cell_ff.mosaic_on;
   assign rsp_bus.mosaic_separated = cell_ff.mosaic_separated;
   assign rsp_bus.tall_cell        = cell_ff.tall_cell;
   assign rsp_bus.spacing_control  = cell_ff.spacing_control;
   assign rsp_bus.last_of_run      = cell_ff.last_of_run;

endmodule
